>>> rtl/sbsm_pkg.sv
`timescale 1ns / 1ps
package sbsm_pkg;

    // Work RAM size in bytes (power of two, 2048 to 32768)
    localparam int PRG_RAM_BYTES = 8192;
    localparam int RAM_AW        = $clog2(PRG_RAM_BYTES);

    // Largest PRG bank count honored for the fixed-last bank
    localparam int MAX_PRG_BANKS = 16;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int MADDR_W = 18;
    localparam int CNT_W   = 5;

    // Opcodes
    localparam logic [1:0] OP_CPU_READ  = 2'd0;
    localparam logic [1:0] OP_CPU_WRITE = 2'd1;
    localparam logic [1:0] OP_PPU_READ  = 2'd2;
    localparam logic [1:0] OP_PPU_WRITE = 2'd3;

    // Result targets
    localparam logic [1:0] TGT_PRG_RAM = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [1:0] TGT_CHR     = 2'd2;
    localparam logic [1:0] TGT_MAPPER  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_BANK_COUNT = 1'b1;

    // Serial register select (address bits 14..13)
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR0    = 2'd1;
    localparam logic [1:0] SEL_CHR1    = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // PRG modes (control bits 3..2)
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

    localparam logic [4:0] CONTROL_RESET = 5'h1C;
    localparam logic [2:0] SHIFT_LAST    = 3'd4;

    // One classified request as it travels from front to back
    typedef struct packed {
        logic [1:0]         target;
        logic [MADDR_W-1:0] mem_address;
        logic               ram_en;
        logic               ram_we;
        logic               chr_write;
        logic [7:0]         data;
        logic [1:0]         mirroring;
    } entry_t;

endpackage

>>> rtl/sbsm_ram.sv
`timescale 1ns / 1ps
module sbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, read data held until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sbsm_front.sv
`timescale 1ns / 1ps
module sbsm_front
    import sbsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        accept,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  data_in,
    output entry_t      entry
);

    logic [CNT_W-1:0] prg_count_reg;
    logic [CNT_W-1:0] chr_count_reg;
    logic [4:0] shift_value_reg, shift_value_next;
    logic [2:0] shift_count_reg, shift_count_next;
    logic [4:0] control_reg, control_next;
    logic [3:0] prg_sel_reg, prg_sel_next;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic [3:0] chr_full_reg, chr_full_next;

    logic [4:0]         shifted;
    logic [CNT_W-1:0]   prg_sat;
    logic [3:0]         last_bank;
    logic [3:0]         prg_bank;
    logic [MADDR_W-1:0] prg_addr;
    logic [MADDR_W-1:0] chr_addr;
    logic [4:0]         chr_bank;
    logic               cpu_low;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= CNT_W'(MAX_PRG_BANKS);
            chr_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRG_BANK_COUNT: prg_count_reg <= cfg_data;
                CFG_CHR_BANK_COUNT: chr_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // PRG translation with the current state
    always_comb
    begin
        if (prg_count_reg == '0)
            prg_sat = CNT_W'(1);
        else if (prg_count_reg > CNT_W'(MAX_PRG_BANKS))
            prg_sat = CNT_W'(MAX_PRG_BANKS);
        else
            prg_sat = prg_count_reg;
        last_bank = 4'(prg_sat - CNT_W'(1));

        if (!address[14])
            prg_bank = (control_reg[3:2] == PRG_MODE_FIX_FIRST) ? 4'd0 : prg_sel_reg;
        else
            prg_bank = (control_reg[3:2] == PRG_MODE_FIX_FIRST) ? prg_sel_reg : last_bank;

        if (!control_reg[3])
            prg_addr = {prg_sel_reg[3:1], address[14:0]};
        else
            prg_addr = {prg_bank, address[13:0]};
    end

    // CHR translation
    always_comb
    begin
        chr_bank = address[12] ? chr_high_reg : chr_low_reg;
        if (chr_count_reg == '0)
            chr_addr = MADDR_W'(address[12:0]);
        else if (control_reg[4])
            chr_addr = MADDR_W'({chr_bank, address[11:0]});
        else
            chr_addr = MADDR_W'({chr_full_reg, address[12:0]});
    end

    // Serial loader
    assign shifted = {data_in[0], shift_value_reg[4:1]};
    assign cpu_low = !address[15];

    always_comb
    begin
        shift_value_next = shift_value_reg;
        shift_count_next = shift_count_reg;
        control_next     = control_reg;
        prg_sel_next     = prg_sel_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        chr_full_next    = chr_full_reg;
        if (accept && opcode == OP_CPU_WRITE && !cpu_low)
        begin
            if (data_in[7])
            begin
                shift_value_next = '0;
                shift_count_next = '0;
                control_next     = control_reg | 5'h0C;
            end
            else if (shift_count_reg != SHIFT_LAST)
            begin
                shift_value_next = shifted;
                shift_count_next = shift_count_reg + 3'd1;
            end
            else
            begin
                shift_value_next = '0;
                shift_count_next = '0;
                case (address[14:13])
                    SEL_CONTROL: control_next = shifted;
                    SEL_CHR0:
                    begin
                        if (control_reg[4])
                            chr_low_next = shifted;
                        else
                            chr_full_next = shifted[4:1];
                    end
                    SEL_CHR1:
                    begin
                        if (control_reg[4])
                            chr_high_next = shifted;
                    end
                    SEL_PRG: prg_sel_next = shifted[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_value_reg <= '0;
            shift_count_reg <= '0;
            control_reg     <= CONTROL_RESET;
            prg_sel_reg     <= '0;
            chr_low_reg     <= '0;
            chr_high_reg    <= '0;
            chr_full_reg    <= '0;
        end
        else
        begin
            shift_value_reg <= shift_value_next;
            shift_count_reg <= shift_count_next;
            control_reg     <= control_next;
            prg_sel_reg     <= prg_sel_next;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            chr_full_reg    <= chr_full_next;
        end
    end

    // Classify the request
    always_comb
    begin
        entry             = '0;
        entry.mirroring   = control_next[1:0];
        entry.data        = data_in;
        case (opcode)
            OP_CPU_READ, OP_CPU_WRITE:
            begin
                if (cpu_low)
                begin
                    entry.target      = TGT_PRG_RAM;
                    entry.mem_address = MADDR_W'(address[RAM_AW-1:0]);
                    entry.ram_en      = 1'b1;
                    entry.ram_we      = (opcode == OP_CPU_WRITE);
                end
                else if (opcode == OP_CPU_READ)
                begin
                    entry.target      = TGT_PRG_ROM;
                    entry.mem_address = prg_addr;
                end
                else
                begin
                    entry.target = TGT_MAPPER;
                end
            end
            default:
            begin
                entry.target      = TGT_CHR;
                entry.mem_address = chr_addr;
                entry.chr_write   = (opcode == OP_PPU_WRITE) && (chr_count_reg == '0);
            end
        endcase
    end

endmodule

>>> rtl/sbsm_queue.sv
`timescale 1ns / 1ps
module sbsm_queue
    import sbsm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    entry_t slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + QUEUE_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QUEUE_CW'(1);
        end
    end

endmodule

>>> rtl/sbsm_back.sv
`timescale 1ns / 1ps
module sbsm_back
    import sbsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  entry_t             q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         target,
    output logic [MADDR_W-1:0] mem_address,
    output logic [7:0]         read_data,
    output logic               chr_write,
    output logic [7:0]         write_data,
    output logic [1:0]         mirroring
);

    logic   valid_reg, valid_next;
    entry_t out_reg;
    logic   ram_read_reg;
    logic [7:0] ram_rdata;

    // Issue when the output slot frees up; the RAM read data then stays put
    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    sbsm_ram #(
        .WIDTH (8),
        .DEPTH (PRG_RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .en    (q_pop && q_head.ram_en),
        .we    (q_head.ram_we),
        .addr  (q_head.mem_address[RAM_AW-1:0]),
        .wdata (q_head.data),
        .rdata (ram_rdata)
    );

    assign valid_next = q_pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg      <= q_head;
            ram_read_reg <= q_head.ram_en && !q_head.ram_we;
        end
    end

    assign out_valid   = valid_reg;
    assign target      = out_reg.target;
    assign mem_address = out_reg.mem_address;
    assign read_data   = ram_read_reg ? ram_rdata : 8'd0;
    assign chr_write   = out_reg.chr_write;
    assign write_data  = out_reg.chr_write ? out_reg.data : 8'd0;
    assign mirroring   = out_reg.mirroring;

endmodule

>>> rtl/serial_bank_switch_mapper_top.sv
`timescale 1ns / 1ps
// Serial-load cartridge bank mapper.
// Stages: front (combinational), queue, output register; the work RAM has a single port.
// Throughput: one request per cycle while out_ready is high; one RAM access per cycle.
// Reset (rst_n, async, active low): mapper registers to power-on values, queue and output
// empty; work RAM contents are undefined until written and need no clearing pass.
module serial_bank_switch_mapper_top
    import sbsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [15:0]        address,
    input  logic [7:0]         data_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         target,
    output logic [MADDR_W-1:0] mem_address,
    output logic [7:0]         read_data,
    output logic               chr_write,
    output logic [7:0]         write_data,
    output logic [1:0]         mirroring
);

    entry_t front_entry;
    entry_t q_head;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    logic   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Front: mapper state and address translation
    sbsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .opcode    (opcode),
        .address   (address),
        .data_in   (data_in),
        .entry     (front_entry)
    );

    // Request queue
    sbsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Back: work RAM access and result register
    sbsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .target      (target),
        .mem_address (mem_address),
        .read_data   (read_data),
        .chr_write   (chr_write),
        .write_data  (write_data),
        .mirroring   (mirroring)
    );

endmodule
